// ===== sv/assert_macros.svh =====
// assertion macros used by the parser
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property that must hold at every clock edge outside reset
`define AMCE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define AMCE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AMCE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define AMCE_ASSERT(lbl, prop, msg)
`define AMCE_ASSERT_IMP(lbl, ante, cons, msg)
`define AMCE_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ===== sv/amce_pkg.sv =====
// types and constants of the avi movi chunk extractor
`default_nettype none

package amce_pkg;

  // parser phase
  typedef enum logic [1:0] {
    PH_SCAN    = 2'd0,
    PH_SIZE    = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_STOPPED = 2'd3
  } phase_e;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned WordW  = 32;
  localparam int unsigned WinW   = 24;

  // little-endian tag words, first byte in the low position
  localparam logic [WordW-1:0] Tag00db = 32'h6264_3030;
  localparam logic [WordW-1:0] Tag00dc = 32'h6364_3030;
  localparam logic [WordW-1:0] Tag01wb = 32'h6277_3130;
  localparam logic [WordW-1:0] Tag00wb = 32'h6277_3030;
  localparam logic [WordW-1:0] TagIdx1 = 32'h3178_6469;
  localparam logic [WordW-1:0] TagIndx = 32'h7864_6e69;

  // last size byte index
  localparam logic [1:0] SizeLast = 2'd3;

  // input beat
  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             restart;
  } in_beat_t;

  // result beat
  typedef struct packed {
    logic [ByteW-1:0] payload_byte;
    logic             frame_start;
    logic             frame_end;
    logic             stream_kind;
    logic [WordW-1:0] byte_offset;
    logic             data_end;
  } out_beat_t;

endpackage

`default_nettype wire

// ===== sv/amce_in_if.sv =====
// input byte channel
`default_nettype none

interface amce_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       restart;

  modport source (output valid, output data_byte, output restart, input ready);
  modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

`default_nettype wire

// ===== sv/amce_out_if.sv =====
// result channel
`default_nettype none

interface amce_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic        frame_start;
  logic        frame_end;
  logic        stream_kind;
  logic [31:0] byte_offset;
  logic        data_end;

  modport source (output valid, output payload_byte, output frame_start, output frame_end,
                  output stream_kind, output byte_offset, output data_end, input ready);
  modport sink   (input valid, input payload_byte, input frame_start, input frame_end,
                  input stream_kind, input byte_offset, input data_end, output ready);
endinterface

`default_nettype wire

// ===== sv/amce_in_stage.sv =====
// input register stage
`default_nettype none

module amce_in_stage (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  amce_in_if.sink                 in_i,
  input  wire logic               adv_i,
  output amce_pkg::in_beat_t      beat_o,
  output logic                    valid_o
);

  logic               valid_q, valid_d;
  amce_pkg::in_beat_t beat_q;
  logic               acc;

  // slot frees when the parser consumes the held beat
  assign in_i.ready = !valid_q || adv_i;
  assign acc        = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (acc) begin
      valid_d = 1'b1;
    end else if (adv_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload capture
  always_ff @(posedge clk_i) begin
    if (acc) begin
      beat_q.data_byte <= in_i.data_byte;
      beat_q.restart   <= in_i.restart;
    end
  end

  assign beat_o  = beat_q;
  assign valid_o = valid_q;

endmodule

`default_nettype wire

// ===== sv/amce_parser.sv =====
// chunk parser state and per-byte decode
`default_nettype none
`include "assert_macros.svh"

module amce_parser (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               step_i,
  input  wire amce_pkg::in_beat_t beat_i,
  output logic                    res_valid_o,
  output amce_pkg::out_beat_t     res_o
);

  amce_pkg::phase_e        phase_q, phase_d, cur_phase;
  logic [23:0]             win_q, win_d, cur_win;
  logic [31:0]             shift_q, shift_d, cur_shift;
  logic [1:0]              cnt_q, cnt_d, cur_cnt;
  logic [31:0]             left_q, left_d, cur_left;
  logic                    kind_q, kind_d, cur_kind;
  logic                    first_q, first_d, cur_first;
  logic [31:0]             pos_q, pos_d, cur_pos;
  logic [31:0]             tag;
  logic [31:0]             shift_nx;
  logic [31:0]             left_m1;
  logic                    is_video, is_audio, is_index;

  // restart forces reset values ahead of this byte
  always_comb begin
    cur_phase = beat_i.restart ? amce_pkg::PH_SCAN : phase_q;
    cur_win   = beat_i.restart ? '0 : win_q;
    cur_shift = beat_i.restart ? '0 : shift_q;
    cur_cnt   = beat_i.restart ? '0 : cnt_q;
    cur_left  = beat_i.restart ? '0 : left_q;
    cur_kind  = beat_i.restart ? 1'b0 : kind_q;
    cur_first = beat_i.restart ? 1'b0 : first_q;
    cur_pos   = beat_i.restart ? '0 : pos_q;
  end

  // tag match and size arithmetic
  assign tag      = {beat_i.data_byte, cur_win};
  assign is_video = (tag == amce_pkg::Tag00db) || (tag == amce_pkg::Tag00dc);
  assign is_audio = (tag == amce_pkg::Tag01wb) || (tag == amce_pkg::Tag00wb);
  assign is_index = (tag == amce_pkg::TagIdx1) || (tag == amce_pkg::TagIndx);
  assign shift_nx = {beat_i.data_byte, cur_shift[31:8]};
  assign left_m1  = cur_left - 32'd1;

  // next state
  always_comb begin
    phase_d = cur_phase;
    win_d   = cur_win;
    shift_d = cur_shift;
    cnt_d   = cur_cnt;
    left_d  = cur_left;
    kind_d  = cur_kind;
    first_d = cur_first;
    pos_d   = cur_pos + 32'd1;
    case (cur_phase)
      amce_pkg::PH_SCAN: begin
        if (is_video || is_audio) begin
          kind_d  = is_audio;
          phase_d = amce_pkg::PH_SIZE;
          shift_d = '0;
          cnt_d   = '0;
          win_d   = '0;
        end else if (is_index) begin
          phase_d = amce_pkg::PH_STOPPED;
          win_d   = '0;
        end else begin
          win_d = tag[31:8];
        end
      end
      amce_pkg::PH_SIZE: begin
        shift_d = shift_nx;
        if (cur_cnt == amce_pkg::SizeLast) begin
          cnt_d = '0;
          if (shift_nx == '0) begin
            phase_d = amce_pkg::PH_SCAN;
          end else begin
            left_d  = shift_nx;
            first_d = 1'b1;
            phase_d = amce_pkg::PH_PAYLOAD;
          end
        end else begin
          cnt_d = cur_cnt + 2'd1;
        end
      end
      amce_pkg::PH_PAYLOAD: begin
        left_d  = left_m1;
        first_d = 1'b0;
        if (left_m1 == '0) begin
          phase_d = amce_pkg::PH_SCAN;
        end
      end
      default: begin
        phase_d = cur_phase;
      end
    endcase
  end

  // result decode
  always_comb begin
    res_valid_o        = 1'b0;
    res_o.payload_byte = '0;
    res_o.frame_start  = 1'b0;
    res_o.frame_end    = 1'b0;
    res_o.stream_kind  = 1'b0;
    res_o.byte_offset  = cur_pos;
    res_o.data_end     = 1'b0;
    case (cur_phase)
      amce_pkg::PH_SCAN: begin
        if (is_index && !is_video && !is_audio) begin
          res_valid_o    = step_i;
          res_o.data_end = 1'b1;
        end
      end
      amce_pkg::PH_PAYLOAD: begin
        res_valid_o        = step_i;
        res_o.payload_byte = beat_i.data_byte;
        res_o.frame_start  = cur_first;
        res_o.frame_end    = (left_m1 == '0);
        res_o.stream_kind  = cur_kind;
      end
      default: begin
        res_valid_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= amce_pkg::PH_SCAN;
      win_q   <= '0;
      shift_q <= '0;
      cnt_q   <= '0;
      left_q  <= '0;
      kind_q  <= 1'b0;
      first_q <= 1'b0;
      pos_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      win_q   <= win_d;
      shift_q <= shift_d;
      cnt_q   <= cnt_d;
      left_q  <= left_d;
      kind_q  <= kind_d;
      first_q <= first_d;
      pos_q   <= pos_d;
    end
  end

  // checks
  `AMCE_ASSERT_IMP(a_payload_nonzero, phase_q == amce_pkg::PH_PAYLOAD, left_q != '0, "payload phase with no bytes left")
  `AMCE_ASSERT_NXT(a_stop_holds, phase_q == amce_pkg::PH_STOPPED && !(step_i && beat_i.restart), phase_q == amce_pkg::PH_STOPPED, "left stopped phase without restart")
  `AMCE_ASSERT_IMP(a_size_window_clear, phase_q == amce_pkg::PH_SIZE, win_q == '0, "tag window not cleared during size capture")
  `AMCE_ASSERT_IMP(a_res_needs_step, res_valid_o, step_i, "result without a consumed beat")

endmodule

`default_nettype wire

// ===== sv/amce_out_stage.sv =====
// result register stage
`default_nettype none

module amce_out_stage (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                res_valid_i,
  input  wire amce_pkg::out_beat_t res_i,
  output logic                     adv_o,
  amce_out_if.source               out_o
);

  logic                valid_q, valid_d;
  amce_pkg::out_beat_t res_q;

  // register loads whenever it is empty or being drained
  assign adv_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (adv_o) begin
      valid_d = res_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload capture
  always_ff @(posedge clk_i) begin
    if (adv_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid        = valid_q;
  assign out_o.payload_byte = res_q.payload_byte;
  assign out_o.frame_start  = res_q.frame_start;
  assign out_o.frame_end    = res_q.frame_end;
  assign out_o.stream_kind  = res_q.stream_kind;
  assign out_o.byte_offset  = res_q.byte_offset;
  assign out_o.data_end     = res_q.data_end;

endmodule

`default_nettype wire

// ===== sv/avi_movi_chunk_extractor_unit.sv =====
// top level of the avi movi chunk extractor
//
//  channel  dir  payload                                           handshake
//  in_i     in   data_byte, restart                                valid/ready
//  out_o    out  payload_byte, frame_start, frame_end,             valid/ready
//                stream_kind, byte_offset, data_end
//
// one byte per cycle sustained while out_o is ready; a byte's result is loaded into the
// result register after acceptance, passing the input register, then the parse logic
// bytes that give no result (media tags, sizes, stray bytes) leave no beat on out_o
// reset clears both stage valids and all parser state; no clearing pass
// a stalled result holds both stages; the input register still takes a byte
// while the result register is full but draining
`default_nettype none

module avi_movi_chunk_extractor_unit (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  amce_in_if.sink    in_i,
  amce_out_if.source out_o
);

  amce_pkg::in_beat_t  beat;
  amce_pkg::out_beat_t res;
  logic                beat_valid;
  logic                res_valid;
  logic                adv;
  logic                step;

  // parser consumes the held beat when the result register can take it
  assign step = beat_valid && adv;

  amce_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .adv_i   (adv),
    .beat_o  (beat),
    .valid_o (beat_valid)
  );

  amce_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .beat_i      (beat),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  amce_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .adv_o       (adv),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

// ===== dv/amce_chunk_checker.sv =====
// checker of the avi movi chunk extractor: parser prediction and beat compare
`default_nettype none

module amce_chunk_checker
  import amce_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  amce_in_if          in_m,
  amce_out_if         out_m,
  output int unsigned fail_cnt_o,
  output int unsigned pending_cnt_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // parser copy kept by the checker
  logic [WinW-1:0]  win_q;
  phase_e           parse_ph;
  logic [WordW-1:0] size_acc;
  logic [1:0]       size_cnt;
  logic [WordW-1:0] remain_cnt;
  logic             kind_q;
  logic             first_q;
  logic [WordW-1:0] pos_q;

  // expected result beats, oldest first
  out_beat_t chunk_beats_q[$];

  initial fail_cnt_o = 0;
  initial pending_cnt_o = 0;

  function automatic void clear_parser();
    win_q      = '0;
    parse_ph   = PH_SCAN;
    size_acc   = '0;
    size_cnt   = '0;
    remain_cnt = '0;
    kind_q     = 1'b0;
    first_q    = 1'b0;
    pos_q      = '0;
  endfunction

  // one byte through the parser, at most one result beat out
  function automatic bit parse_byte(input logic [7:0] b, input logic rs, output out_beat_t res);
    logic [WordW-1:0] word;
    logic [WordW-1:0] off;
    bit               hit;
    hit = 1'b0;
    res = '0;
    if (rs) clear_parser();
    off   = pos_q;
    pos_q = pos_q + 32'd1;
    case (parse_ph)
      PH_SCAN: begin
        word = {b, win_q};
        if (word == Tag00db || word == Tag00dc || word == Tag01wb || word == Tag00wb) begin
          kind_q   = (word == Tag01wb || word == Tag00wb);
          parse_ph = PH_SIZE;
          size_acc = '0;
          size_cnt = '0;
          win_q    = '0;
        end else if (word == TagIdx1 || word == TagIndx) begin
          // index reached: data-end beat, then stopped until restart
          parse_ph         = PH_STOPPED;
          win_q            = '0;
          res.byte_offset  = off;
          res.data_end     = 1'b1;
          hit              = 1'b1;
        end else begin
          win_q = word[WordW-1:8];
        end
      end
      PH_SIZE: begin
        size_acc = {b, size_acc[WordW-1:8]};
        if (size_cnt == SizeLast) begin
          size_cnt = '0;
          // zero size skips the chunk
          if (size_acc == '0) begin
            parse_ph = PH_SCAN;
          end else begin
            remain_cnt = size_acc;
            first_q    = 1'b1;
            parse_ph   = PH_PAYLOAD;
          end
        end else begin
          size_cnt = size_cnt + 2'd1;
        end
      end
      PH_PAYLOAD: begin
        remain_cnt       = remain_cnt - 32'd1;
        res.payload_byte = b;
        res.frame_start  = first_q;
        res.frame_end    = (remain_cnt == '0);
        res.stream_kind  = kind_q;
        res.byte_offset  = off;
        hit              = 1'b1;
        first_q          = 1'b0;
        if (remain_cnt == '0) parse_ph = PH_SCAN;
      end
      default: ;
    endcase
    return hit;
  endfunction

  // predict on accepted input beats, compare accepted result beats
  always @(posedge clk_i) begin : watch
    out_beat_t want;
    out_beat_t got;
    if (!rst_ni) begin
      clear_parser();
      chunk_beats_q.delete();
    end else begin
      if (in_m.valid && in_m.ready) begin
        if (parse_byte(in_m.data_byte, in_m.restart, want)) chunk_beats_q.push_back(want);
      end
      if (out_m.valid && out_m.ready) begin
        got.payload_byte = out_m.payload_byte;
        got.frame_start  = out_m.frame_start;
        got.frame_end    = out_m.frame_end;
        got.stream_kind  = out_m.stream_kind;
        got.byte_offset  = out_m.byte_offset;
        got.data_end     = out_m.data_end;
        if (chunk_beats_q.size() == 0) begin
          $error("result beat with nothing expected: offset %0d", got.byte_offset);
          fail_cnt_o++;
        end else begin
          want = chunk_beats_q.pop_front();
          if (got.payload_byte !== want.payload_byte) begin
            $error("payload_byte: expected %0h, actual %0h", want.payload_byte,
                   got.payload_byte);
            fail_cnt_o++;
          end
          if (got.frame_start !== want.frame_start) begin
            $error("frame_start: expected %0b, actual %0b", want.frame_start, got.frame_start);
            fail_cnt_o++;
          end
          if (got.frame_end !== want.frame_end) begin
            $error("frame_end: expected %0b, actual %0b", want.frame_end, got.frame_end);
            fail_cnt_o++;
          end
          if (got.stream_kind !== want.stream_kind) begin
            $error("stream_kind: expected %0b, actual %0b", want.stream_kind, got.stream_kind);
            fail_cnt_o++;
          end
          if (got.byte_offset !== want.byte_offset) begin
            $error("byte_offset: expected %0d, actual %0d", want.byte_offset,
                   got.byte_offset);
            fail_cnt_o++;
          end
          if (got.data_end !== want.data_end) begin
            $error("data_end: expected %0b, actual %0b", want.data_end, got.data_end);
            fail_cnt_o++;
          end
        end
      end
    end
    pending_cnt_o = chunk_beats_q.size();
  end

endmodule

`default_nettype wire

// ===== dv/tb_avi_movi_chunk_extractor_unit.sv =====
// testbench top of the avi movi chunk extractor: byte stimulus and verdict
`default_nettype none

module tb_avi_movi_chunk_extractor_unit;
  import amce_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [WordW-1:0] JunkTag = 32'h4b4e_554a;
  localparam logic [WordW-1:0] MediaTags [4] = '{Tag00db, Tag00dc, Tag01wb, Tag00wb};
  localparam int unsigned RandBytes = 600;

  logic clk_i = 1'b0;
  logic rst_ni;

  // stimulus controls
  bit          idle_on     = 1'b1;
  bit          hold_req    = 1'b0;
  bit          restart_due = 1'b0;
  int unsigned sent_cnt    = 0;
  int unsigned fail_cnt;
  int unsigned pending_cnt;

  amce_in_if  in_c ();
  amce_out_if out_c ();

  avi_movi_chunk_extractor_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_c),
    .out_o  (out_c)
  );

  amce_chunk_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_m          (in_c),
    .out_m         (out_c),
    .fail_cnt_o    (fail_cnt),
    .pending_cnt_o (pending_cnt)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  // one input beat, with an optional gap before it
  task automatic send_beat(input logic [7:0] b);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_c.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_c.valid     <= 1'b1;
    in_c.data_byte <= b;
    in_c.restart   <= restart_due;
    restart_due = 1'b0;
    do @(posedge clk_i); while (!in_c.ready);
    sent_cnt++;
  endtask

  // four bytes, low byte first
  task automatic send_word(input logic [WordW-1:0] w);
    for (int i = 0; i < 4; i++) send_beat(w[8*i +: 8]);
  endtask

  // chunk header and the first n_pay payload bytes
  task automatic send_chunk(input logic [WordW-1:0] tag, input logic [WordW-1:0] size,
                            input int unsigned n_pay);
    send_word(tag);
    send_word(size);
    for (int unsigned i = 0; i < n_pay; i++) send_beat(8'($urandom));
  endtask

  // result side: random stall bursts, one long hold on request
  initial begin
    out_c.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_c.ready <= 1'b0;
        repeat (120) @(posedge clk_i);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_c.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
      end else begin
        out_c.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // stimulus
  initial begin
    logic [WordW-1:0] w;
    int unsigned      sz;
    in_c.valid     = 1'b0;
    in_c.data_byte = '0;
    in_c.restart   = 1'b0;
    rst_ni         = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: every tag, edge sizes, stray bytes, stop and restart
    send_chunk(Tag00db, 32'd1, 1);
    send_chunk(Tag00dc, 32'd2, 2);
    send_chunk(Tag01wb, 32'd3, 3);
    send_chunk(Tag00wb, 32'd0, 0);
    send_beat(8'h00);
    send_beat(8'hff);
    send_chunk(Tag00dc, 32'hffff_ffff, 3);
    restart_due = 1'b1;
    send_chunk(Tag00wb, 32'h8000_0001, 2);
    restart_due = 1'b1;
    send_word(TagIdx1);
    send_beat(8'h30);
    send_beat(8'hff);
    restart_due = 1'b1;
    send_word(TagIndx);
    restart_due = 1'b1;

    // long receiver hold while a long chunk keeps coming
    hold_req = 1'b1;
    send_chunk(Tag00db, 32'd60, 60);

    // random: mostly well-formed chunks, some noise and broken sequences
    while (sent_cnt < RandBytes) begin
      idle_on = (sent_cnt < RandBytes - 100) && ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 19))
        12, 13: begin
          if ($urandom_range(0, 1) == 0) send_word(JunkTag);
          repeat ($urandom_range(1, 4)) send_beat(8'($urandom));
        end
        14: begin
          w = MediaTags[$urandom_range(0, 3)];
          for (int i = 0; i < $urandom_range(1, 3); i++) send_beat(w[8*i +: 8]);
          send_beat(8'($urandom));
        end
        15: begin
          send_chunk(MediaTags[$urandom_range(0, 3)], $urandom | 32'h0100_0000,
                     $urandom_range(0, 4));
          restart_due = 1'b1;
        end
        16: begin
          send_word($urandom_range(0, 1) ? TagIdx1 : TagIndx);
          repeat ($urandom_range(0, 3)) send_beat(8'($urandom));
          restart_due = 1'b1;
        end
        17: begin
          restart_due = 1'b1;
          send_beat(8'($urandom));
        end
        default: begin
          sz = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 64) : $urandom_range(0, 12);
          send_chunk(MediaTags[$urandom_range(0, 3)], sz, sz);
        end
      endcase
    end
    in_c.valid <= 1'b0;

    // drain, then a short tail for stray beats
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
